// ===== hw/rtl/zld_pkg.sv =====
// ----------------------------------------------------------------------------
// zld_pkg
// Shared types and constants for the zip local header deframer.
// ----------------------------------------------------------------------------
package zld_pkg;

    localparam int unsigned HdrBytes = 30;
    localparam int unsigned StoreBytes = HdrBytes - 1;
    localparam int unsigned CntW = $clog2(HdrBytes);
    localparam logic [CntW-1:0] CntLast = CntW'(HdrBytes - 1);

    localparam logic [31:0] SigLocal = 32'h0403_4b50;
    localparam logic [31:0] SigCentral = 32'h0201_4b50;
    localparam logic [15:0] FlagBadMask = 16'hFFFC;
    localparam logic [15:0] MaxVersionReset = 16'd20;

    // byte_kind codes
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_HEADER_LAST = 3'd1;
    localparam logic [2:0] KIND_NAME = 3'd2;
    localparam logic [2:0] KIND_EXTRA = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_EXTRA   = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_IGNORE  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [15:0] compression_method;
        logic [31:0] crc_value;
        logic [31:0] comp_size;
        logic [31:0] raw_size;
        logic [15:0] name_length;
        logic [15:0] extra_length;
        logic [15:0] mod_time;
        logic [15:0] mod_date;
    } t_hdr_fields;

    typedef struct packed {
        logic central;
        logic bad_sig;
        logic unsupported;
    } t_hdr_chk;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  out_byte;
        logic        entry_end;
        logic [1:0]  status;
        t_hdr_fields fields;
    } t_result;

    // Next section that still has bytes; header when the entry is done.
    function automatic t_phase pick_phase(input logic [15:0] name_rem,
                                          input logic [15:0] extra_left,
                                          input logic [31:0] payload_left);
        t_phase ph;
        if (name_rem != '0) begin
            ph = PH_NAME;
        end else if (extra_left != '0) begin
            ph = PH_EXTRA;
        end else if (payload_left != '0) begin
            ph = PH_PAYLOAD;
        end else begin
            ph = PH_HEADER;
        end
        return ph;
    endfunction

endpackage

// ===== hw/rtl/zld_hdr_decode.sv =====
// ----------------------------------------------------------------------------
// zld_hdr_decode
// Splits a complete 30-byte local header into fields and checks it.
// ----------------------------------------------------------------------------
module zld_hdr_decode (
    input  logic [zld_pkg::StoreBytes-1:0][7:0] i_hdr,
    input  logic [7:0]                          i_last_byte,
    input  logic [15:0]                         i_max_version,
    output zld_pkg::t_hdr_fields                o_fields,
    output zld_pkg::t_hdr_chk                   o_chk
);

    logic [zld_pkg::HdrBytes-1:0][7:0] w;
    logic [31:0] sig;
    logic [15:0] ver;
    logic [15:0] flags;

    assign w = {i_last_byte, i_hdr};

    assign sig   = {w[3], w[2], w[1], w[0]};
    assign ver   = {w[5], w[4]};
    assign flags = {w[7], w[6]};

    assign o_fields.compression_method = {w[9], w[8]};
    assign o_fields.mod_time           = {w[11], w[10]};
    assign o_fields.mod_date           = {w[13], w[12]};
    assign o_fields.crc_value          = {w[17], w[16], w[15], w[14]};
    assign o_fields.comp_size          = {w[21], w[20], w[19], w[18]};
    assign o_fields.raw_size           = {w[25], w[24], w[23], w[22]};
    assign o_fields.name_length        = {w[27], w[26]};
    assign o_fields.extra_length       = {w[29], w[28]};

    assign o_chk.central     = (sig == zld_pkg::SigCentral);
    assign o_chk.bad_sig     = (sig != zld_pkg::SigLocal);
    assign o_chk.unsupported = (ver > i_max_version) ||
                               ((flags & zld_pkg::FlagBadMask) != '0);

endmodule

// ===== hw/rtl/zld_seq.sv =====
// ----------------------------------------------------------------------------
// zld_seq
// Per-byte entry sequencer: header store, section counters, sticky error.
// ----------------------------------------------------------------------------
module zld_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic [15:0]      i_max_version,
    output zld_pkg::t_result o_result
);

    zld_pkg::t_phase            r_phase, n_phase;
    logic [zld_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic [15:0]                r_name, n_name;
    logic [15:0]                r_extra, n_extra;
    logic [31:0]                r_pay, n_pay;
    logic [1:0]                 r_err, n_err;
    logic [7:0]                 r_hdr [zld_pkg::StoreBytes];
    logic                       hdr_wr;

    logic [zld_pkg::StoreBytes-1:0][7:0] hdr_flat;
    zld_pkg::t_hdr_fields       dec_fields;
    zld_pkg::t_hdr_chk          dec_chk;
    zld_pkg::t_phase            nxt;

    always_comb begin
        for (int k = 0; k < zld_pkg::StoreBytes; k++) begin
            hdr_flat[k] = r_hdr[k];
        end
    end

    zld_hdr_decode u_dec (
        .i_hdr         (hdr_flat),
        .i_last_byte   (i_byte),
        .i_max_version (i_max_version),
        .o_fields      (dec_fields),
        .o_chk         (dec_chk)
    );

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_name  = r_name;
        n_extra = r_extra;
        n_pay   = r_pay;
        n_err   = r_err;
        hdr_wr  = 1'b0;
        nxt     = zld_pkg::PH_HEADER;
        o_result.byte_kind = zld_pkg::KIND_IGNORED;
        o_result.out_byte  = i_byte;
        o_result.entry_end = 1'b0;
        o_result.fields    = '0;
        case (r_phase)
            zld_pkg::PH_HEADER: begin
                if (r_cnt == zld_pkg::CntLast) begin
                    n_cnt = '0;
                    if (dec_chk.central) begin
                        n_phase = zld_pkg::PH_IGNORE;
                    end else if (dec_chk.bad_sig) begin
                        n_err   = zld_pkg::ST_BAD_SIG;
                        n_phase = zld_pkg::PH_IGNORE;
                    end else if (dec_chk.unsupported) begin
                        n_err   = zld_pkg::ST_UNSUPPORTED;
                        n_phase = zld_pkg::PH_IGNORE;
                    end else begin
                        o_result.byte_kind = zld_pkg::KIND_HEADER_LAST;
                        o_result.fields    = dec_fields;
                        n_name  = dec_fields.name_length;
                        n_extra = dec_fields.extra_length;
                        n_pay   = dec_fields.comp_size;
                        nxt     = zld_pkg::pick_phase(n_name, n_extra, n_pay);
                        n_phase = nxt;
                        o_result.entry_end = (nxt == zld_pkg::PH_HEADER);
                    end
                end else begin
                    hdr_wr = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    o_result.byte_kind = zld_pkg::KIND_HEADER;
                end
            end
            zld_pkg::PH_NAME: begin
                o_result.byte_kind = zld_pkg::KIND_NAME;
                n_name  = r_name - 1'b1;
                nxt     = zld_pkg::pick_phase(n_name, r_extra, r_pay);
                n_phase = nxt;
                o_result.entry_end = (nxt == zld_pkg::PH_HEADER);
            end
            zld_pkg::PH_EXTRA: begin
                o_result.byte_kind = zld_pkg::KIND_EXTRA;
                n_extra = r_extra - 1'b1;
                nxt     = zld_pkg::pick_phase(r_name, n_extra, r_pay);
                n_phase = nxt;
                o_result.entry_end = (nxt == zld_pkg::PH_HEADER);
            end
            zld_pkg::PH_PAYLOAD: begin
                o_result.byte_kind = zld_pkg::KIND_PAYLOAD;
                n_pay   = r_pay - 1'b1;
                nxt     = zld_pkg::pick_phase(r_name, r_extra, n_pay);
                n_phase = nxt;
                o_result.entry_end = (nxt == zld_pkg::PH_HEADER);
            end
            default: begin
                n_phase = zld_pkg::PH_IGNORE;
            end
        endcase
        o_result.status = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= zld_pkg::PH_HEADER;
            r_cnt   <= '0;
            r_name  <= '0;
            r_extra <= '0;
            r_pay   <= '0;
            r_err   <= zld_pkg::ST_OK;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_name  <= n_name;
            r_extra <= n_extra;
            r_pay   <= n_pay;
            r_err   <= n_err;
        end
    end

    // Header store: bytes 0..28; the last byte is decoded straight from input.
    always_ff @(posedge i_clk) begin
        if (i_advance && hdr_wr) begin
            r_hdr[r_cnt] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/zip_local_header_deframer.sv =====
// ----------------------------------------------------------------------------
// zip_local_header_deframer
// Tags every byte of a zip stream: local header, name, extra, payload or
// ignored, and reports header fields on the last byte of an accepted header.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | dir | handshake
//  --------+------------------------------------------+-----+----------------
//  in      | i_data_byte                              | in  | i_in_valid/o_in_ready
//  out     | o_byte_kind .. o_mod_date                | out | o_out_valid/i_out_ready
//  cfg     | i_cfg_wdata (max_version)                | in  | i_cfg_we, no wait
//
//  One byte per cycle sustained while the output is not stalled; an accepted
//  byte passes through the input register, then the per-byte sequencer into
//  the result register.
//  Reset (synchronous, active low) clears phase, counters, sticky error and
//  both valid flags; max_version returns to 20.
//  A stalled output holds the result register; the input register still
//  refills when its byte moves on, so a full pipe holds two transactions.
//
module zip_local_header_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    // result transaction
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_byte_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_entry_end,
    output logic [1:0]  o_status,
    output logic [15:0] o_compression_method,
    output logic [31:0] o_crc_value,
    output logic [31:0] o_comp_size,
    output logic [31:0] o_raw_size,
    output logic [15:0] o_name_length,
    output logic [15:0] o_extra_length,
    output logic [15:0] o_mod_time,
    output logic [15:0] o_mod_date,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    zld_pkg::t_result r_out;
    logic [15:0]      r_max_version;

    logic             advance;
    zld_pkg::t_result seq_result;

    // The input-register byte is processed when the result register is free
    // or being drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_version <= zld_pkg::MaxVersionReset;
        end else if (i_cfg_we) begin
            r_max_version <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    zld_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_byte        (r_in_byte),
        .i_max_version (r_max_version),
        .o_result      (seq_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_byte_kind          = r_out.byte_kind;
    assign o_out_byte           = r_out.out_byte;
    assign o_entry_end          = r_out.entry_end;
    assign o_status             = r_out.status;
    assign o_compression_method = r_out.fields.compression_method;
    assign o_crc_value          = r_out.fields.crc_value;
    assign o_comp_size          = r_out.fields.comp_size;
    assign o_raw_size           = r_out.fields.raw_size;
    assign o_name_length        = r_out.fields.name_length;
    assign o_extra_length       = r_out.fields.extra_length;
    assign o_mod_time           = r_out.fields.mod_time;
    assign o_mod_date           = r_out.fields.mod_date;

endmodule

// ===== test/zip_local_header_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// zip_local_header_deframer_tb
// Streams well-formed zip entries byte by byte through the deframer, with
// random gaps on both channels, across several max_version settings, and ends
// each run on one random terminating header (central directory, bad
// signature, version too high or a flag bit that is not allowed). Every result
// transaction is checked field by field against an in-bench tagger that
// tracks the header, name, extra and payload sections.
// ----------------------------------------------------------------------------
module zip_local_header_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transaction on either channel before giving up;
    // the longest legal stall is the forced receiver hold-off (RxHoldCycles)
    localparam int unsigned StallLimit = 2000;
    localparam int unsigned RxHoldCycles = 300;

    // terminating header kinds
    typedef enum int {
        END_CENTRAL,
        END_BAD_SIG,
        END_BAD_VERSION,
        END_BAD_FLAGS
    } t_end_kind;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_out_byte;
    logic        o_entry_end;
    logic [1:0]  o_status;
    logic [15:0] o_compression_method;
    logic [31:0] o_crc_value;
    logic [31:0] o_comp_size;
    logic [31:0] o_raw_size;
    logic [15:0] o_name_length;
    logic [15:0] o_extra_length;
    logic [15:0] o_mod_time;
    logic [15:0] o_mod_date;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    zip_local_header_deframer dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_data_byte          (i_data_byte),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_byte_kind          (o_byte_kind),
        .o_out_byte           (o_out_byte),
        .o_entry_end          (o_entry_end),
        .o_status             (o_status),
        .o_compression_method (o_compression_method),
        .o_crc_value          (o_crc_value),
        .o_comp_size          (o_comp_size),
        .o_raw_size           (o_raw_size),
        .o_name_length        (o_name_length),
        .o_extra_length       (o_extra_length),
        .o_mod_time           (o_mod_time),
        .o_mod_date           (o_mod_date),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [7:0]       pending_bytes[$];   // archive bytes not yet offered
    zld_pkg::t_result tags_due[$];        // expected result per accepted byte
    int unsigned      queued_bytes = 0;
    int unsigned      mismatches = 0;
    int unsigned      stall_cycles = 0;
    int unsigned      rx_hold = 0;        // receiver hold-off, counted down below
    bit               tx_pause = 1'b0;    // sender offers nothing while set
    bit               no_idle = 1'b0;     // both sides run flat out while set
    bit               byte_taken = 1'b0;  // input transaction at the last rising edge
    zld_pkg::t_result got_r;
    zld_pkg::t_result want_r;

    // Tagger state: mirrors the deframer's section tracking
    zld_pkg::t_phase  entry_phase = zld_pkg::PH_HEADER;
    int unsigned      hdr_cnt = 0;
    logic [7:0]       hdr_buf [zld_pkg::HdrBytes];
    logic [15:0]      name_rem = '0;
    logic [15:0]      extra_left = '0;
    logic [31:0]      payload_left = '0;
    logic [1:0]       err_code = zld_pkg::ST_OK;
    logic [15:0]      max_ver = zld_pkg::MaxVersionReset;

    // ------------------------------------------------------------------------
    // Tagger
    // ------------------------------------------------------------------------
    function automatic logic [15:0] hdr16(input int at);
        return {hdr_buf[at+1], hdr_buf[at]};
    endfunction

    function automatic logic [31:0] hdr32(input int at);
        return {hdr16(at + 2), hdr16(at)};
    endfunction

    // Moves on to the next section with bytes left; 1 when the entry is done.
    function automatic logic next_section();
        if (name_rem != '0) begin
            entry_phase = zld_pkg::PH_NAME;
        end else if (extra_left != '0) begin
            entry_phase = zld_pkg::PH_EXTRA;
        end else if (payload_left != '0) begin
            entry_phase = zld_pkg::PH_PAYLOAD;
        end else begin
            entry_phase = zld_pkg::PH_HEADER;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expected result for one accepted archive byte; updates tagger state.
    function automatic zld_pkg::t_result tag_byte(input logic [7:0] b);
        zld_pkg::t_result r;
        logic [31:0]      sig;
        r = '0;
        r.out_byte = b;
        r.byte_kind = zld_pkg::KIND_IGNORED;
        case (entry_phase)
            zld_pkg::PH_HEADER: begin
                hdr_buf[hdr_cnt] = b;
                if (hdr_cnt < zld_pkg::HdrBytes - 1) begin
                    hdr_cnt++;
                    r.byte_kind = zld_pkg::KIND_HEADER;
                end else begin
                    hdr_cnt = 0;
                    sig = hdr32(0);
                    if (sig == zld_pkg::SigCentral) begin
                        entry_phase = zld_pkg::PH_IGNORE;
                    end else if (sig != zld_pkg::SigLocal) begin
                        err_code = zld_pkg::ST_BAD_SIG;
                        entry_phase = zld_pkg::PH_IGNORE;
                    end else if (hdr16(4) > max_ver ||
                                 (hdr16(6) & zld_pkg::FlagBadMask) != '0) begin
                        err_code = zld_pkg::ST_UNSUPPORTED;
                        entry_phase = zld_pkg::PH_IGNORE;
                    end else begin
                        r.byte_kind = zld_pkg::KIND_HEADER_LAST;
                        r.fields.compression_method = hdr16(8);
                        r.fields.mod_time = hdr16(10);
                        r.fields.mod_date = hdr16(12);
                        r.fields.crc_value = hdr32(14);
                        r.fields.comp_size = hdr32(18);
                        r.fields.raw_size = hdr32(22);
                        r.fields.name_length = hdr16(26);
                        r.fields.extra_length = hdr16(28);
                        name_rem = hdr16(26);
                        extra_left = hdr16(28);
                        payload_left = hdr32(18);
                        r.entry_end = next_section();
                    end
                end
            end
            zld_pkg::PH_NAME: begin
                r.byte_kind = zld_pkg::KIND_NAME;
                if (name_rem != '0) name_rem--;
                r.entry_end = next_section();
            end
            zld_pkg::PH_EXTRA: begin
                r.byte_kind = zld_pkg::KIND_EXTRA;
                if (extra_left != '0) extra_left--;
                r.entry_end = next_section();
            end
            zld_pkg::PH_PAYLOAD: begin
                r.byte_kind = zld_pkg::KIND_PAYLOAD;
                if (payload_left != '0) payload_left--;
                r.entry_end = next_section();
            end
            default: begin
                entry_phase = zld_pkg::PH_IGNORE;
            end
        endcase
        r.status = err_code;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: drive at the falling edge, record transactions at the rising
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && i_in_valid && o_in_ready;
        if (byte_taken) tags_due.push_back(tag_byte(i_data_byte));
    end

    // valid holds with the same byte until the transaction completes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            if (pending_bytes.size() != 0 && !tx_pause &&
                (no_idle || $urandom_range(99) >= 27)) begin
                i_in_valid <= 1'b1;
                i_data_byte <= pending_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random back-pressure plus the long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            i_out_ready <= 1'b0;
            rx_hold--;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_r.byte_kind = o_byte_kind;
            got_r.out_byte = o_out_byte;
            got_r.entry_end = o_entry_end;
            got_r.status = o_status;
            got_r.fields.compression_method = o_compression_method;
            got_r.fields.crc_value = o_crc_value;
            got_r.fields.comp_size = o_comp_size;
            got_r.fields.raw_size = o_raw_size;
            got_r.fields.name_length = o_name_length;
            got_r.fields.extra_length = o_extra_length;
            got_r.fields.mod_time = o_mod_time;
            got_r.fields.mod_date = o_mod_date;
            if (tags_due.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual kind %0h byte %0h", $time,
                         got_r.byte_kind, got_r.out_byte);
            end else begin
                want_r = tags_due.pop_front();
                check_field("byte_kind", 32'(got_r.byte_kind), 32'(want_r.byte_kind));
                check_field("out_byte", 32'(got_r.out_byte), 32'(want_r.out_byte));
                check_field("entry_end", 32'(got_r.entry_end), 32'(want_r.entry_end));
                check_field("status", 32'(got_r.status), 32'(want_r.status));
                check_field("compression_method",
                            32'(got_r.fields.compression_method),
                            32'(want_r.fields.compression_method));
                check_field("crc_value", got_r.fields.crc_value, want_r.fields.crc_value);
                check_field("comp_size", got_r.fields.comp_size, want_r.fields.comp_size);
                check_field("raw_size", got_r.fields.raw_size, want_r.fields.raw_size);
                check_field("name_length", 32'(got_r.fields.name_length),
                            32'(want_r.fields.name_length));
                check_field("extra_length", 32'(got_r.fields.extra_length),
                            32'(want_r.fields.extra_length));
                check_field("mod_time", 32'(got_r.fields.mod_time),
                            32'(want_r.fields.mod_time));
                check_field("mod_date", 32'(got_r.fields.mod_date),
                            32'(want_r.fields.mod_date));
            end
        end
    end

    // Watchdog: any transaction on either channel resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("zip_local_header_deframer_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // misc = {usize, crc, mod_date, mod_time, method}
    task automatic push_entry(input logic [31:0] sig, input logic [15:0] ver,
                              input logic [15:0] flg, input logic [15:0] nlen,
                              input logic [15:0] xlen, input logic [31:0] csz,
                              input logic [111:0] misc);
        logic [239:0] h;
        int unsigned  body_len;
        // header is little-endian; byte 0 is the low signature byte
        h = {xlen, nlen, misc[111:80], csz, misc[79:48], misc[47:32], misc[31:16],
             misc[15:0], flg, ver, sig};
        body_len = nlen + xlen + csz;
        for (int i = 0; i < zld_pkg::HdrBytes; i++) pending_bytes.push_back(h[8*i +: 8]);
        for (int unsigned k = 0; k < body_len; k++) begin
            pending_bytes.push_back(8'($urandom_range(255)));
        end
        queued_bytes += zld_pkg::HdrBytes + body_len;
    endtask

    // Well-formed entries under the current max_version; mostly short bodies
    task automatic push_random_entries(input int unsigned target);
        int unsigned start;
        logic [15:0] ver;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [31:0] csz;
        start = queued_bytes;
        while (queued_bytes - start < target) begin
            ver = ($urandom_range(9) == 0) ? max_ver : 16'($urandom_range(max_ver));
            if ($urandom_range(39) == 0) begin
                nlen = 16'($urandom_range(300));
                xlen = 16'($urandom_range(100));
                csz = $urandom_range(600);
            end else begin
                nlen = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(8));
                xlen = ($urandom_range(2) == 0) ? 16'($urandom_range(6)) : 16'd0;
                csz = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(24);
            end
            push_entry(zld_pkg::SigLocal, ver, 16'($urandom_range(3)), nlen, xlen, csz,
                       112'({$urandom, $urandom, $urandom, $urandom}));
        end
    endtask

    // Sampled just after the rising edge, when all edge activity has settled
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_bytes.size() != 0 || i_in_valid || tags_due.size() != 0);
    endtask

    // Register write only with the pipe empty
    task automatic set_max_version(input logic [15:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_ver = v;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_end_kind   end_kind;
        logic [31:0] sig;
        logic [15:0] ver;
        logic [15:0] flg;

        foreach (hdr_buf[i]) hdr_buf[i] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset max_version of 20:
        // empty entry at the version limit with both allowed flags, all-ones fields
        push_entry(zld_pkg::SigLocal, 16'd20, 16'h0003, 16'd0, 16'd0, 32'd0, '1);
        // all three sections, zero fields
        push_entry(zld_pkg::SigLocal, 16'd0, 16'h0000, 16'd2, 16'd1, 32'd3, '0);
        // name only, extra only, payload only
        push_entry(zld_pkg::SigLocal, 16'd9, 16'h0001, 16'd1, 16'd0, 32'd0,
                   112'({$urandom, $urandom, $urandom, $urandom}));
        push_entry(zld_pkg::SigLocal, 16'd20, 16'h0002, 16'd0, 16'd2, 32'd0,
                   112'({$urandom, $urandom, $urandom, $urandom}));
        push_entry(zld_pkg::SigLocal, 16'd1, 16'h0000, 16'd0, 16'd0, 32'd5,
                   112'({$urandom, $urandom, $urandom, $urandom}));

        // Widest limit; receiver holds off while the sender keeps offering
        set_max_version(16'hFFFF);
        push_entry(zld_pkg::SigLocal, 16'hFFFF, 16'h0003, 16'd0, 16'd0, 32'd1,
                   112'({$urandom, $urandom, $urandom, $urandom}));
        push_random_entries(270);
        @(posedge i_clk);
        #1;
        rx_hold = RxHoldCycles;

        // Tightest limit; sender pauses mid-phase until every result is back
        set_max_version(16'h0000);
        push_random_entries(270);
        while (pending_bytes.size() > 150) @(posedge i_clk);
        #1;
        tx_pause = 1'b1;
        do begin
            @(posedge i_clk);
            #1;
        end while (i_in_valid || tags_due.size() != 0);
        tx_pause = 1'b0;

        // Mid-range limit, no idling on either side
        set_max_version(16'($urandom_range(65534, 1)));
        #1;
        no_idle = 1'b1;
        push_random_entries(270);
        wait_drained();
        no_idle = 1'b0;

        set_max_version(16'($urandom_range(65534, 1)));
        push_random_entries(270);

        // One terminating header per run; everything after it is ignored
        end_kind = t_end_kind'($urandom_range(3));
        sig = zld_pkg::SigLocal;
        ver = 16'($urandom_range(max_ver));
        flg = 16'($urandom_range(3));
        case (end_kind)
            END_CENTRAL: sig = zld_pkg::SigCentral;
            END_BAD_SIG: begin
                sig = $urandom;
                if (sig == zld_pkg::SigLocal || sig == zld_pkg::SigCentral) sig ^= 32'h1;
            end
            END_BAD_VERSION: ver = max_ver + 16'd1;
            default: flg = 16'($urandom) | (16'h1 << $urandom_range(15, 2));
        endcase
        push_entry(sig, ver, flg, 16'($urandom_range(8)), 16'($urandom_range(4)),
                   $urandom_range(16), 112'({$urandom, $urandom, $urandom, $urandom}));
        repeat (40) pending_bytes.push_back(8'($urandom_range(255)));

        wait_drained();
        // pipe is two deep; keep clocking to catch any stray result
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && tags_due.size() == 0) begin
            $display("zip_local_header_deframer_tb: clean");
        end else begin
            $display("zip_local_header_deframer_tb: errors");
        end
        $finish;
    end

endmodule
